[rtl/run_length_statistics_unit_defines.svh]
// assertion macros for the run length statistics unit
// no dependencies; included by the checker file
`ifndef RUN_LENGTH_STATISTICS_UNIT_DEFINES_SVH
`define RUN_LENGTH_STATISTICS_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RLS_ASSERT_IMPL(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
    else $error("rls implication check failed");

// next-cycle implication, disabled in reset
`define RLS_ASSERT_NEXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
    else $error("rls next-cycle check failed");

// next-cycle implication, active through reset
`define RLS_ASSERT_NEXT_ALWAYS(lbl, ck, a, b) \
  lbl: assert property (@(posedge ck) (a) |=> (b)) \
    else $error("rls reset check failed");

`endif

[rtl/rls_pkg.sv]
// shared constants and types of the run length statistics unit
// no dependencies
package rls_pkg;

  localparam int COUNT_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int TEXT_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int TOTAL_W   = 16;
  localparam int LONG_W    = 16;
  localparam int STAT_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK  = 1'b1;

  localparam logic [CFG_W-1:0]  SEARCH_RST = 8'd1;
  localparam logic [CFG_W-1:0]  BREAK_RST  = 8'd32;
  localparam logic [TEXT_W-1:0] END_BYTE   = 8'd0;

  localparam int QUEUE_DEPTH = 2;

  // quotient width for the variance; values at or above 2^(ROOT_W-1) saturate
  localparam int ROOT_W = 57;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SUB  = 7'b0000100,
    ST_MDIV = 7'b0001000,
    ST_DDIV = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_DONE = 7'b1000000
  } back_state_t;

endpackage

[rtl/run_length_statistics_unit.sv]
// throughput: one text byte per cycle unless the request queue is full; one string end per
//   back-part pass, with a two-entry request queue absorbing short strings
// reset: synchronous active low; clears accumulators, queue and output valid,
//   search register to 1 and break register to 32
module run_length_statistics_unit #(
  parameter int COUNT_BITS    = rls_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = rls_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rls_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rls_pkg::TEXT_W-1:0]    in_text_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rls_pkg::TOTAL_W-1:0]   out_run_total,
  output logic [rls_pkg::LONG_W-1:0]    out_longest_run,
  output logic [rls_pkg::STAT_W-1:0]    out_mean_q8,
  output logic [rls_pkg::STAT_W-1:0]    out_deviation_q8,
  output logic                          out_overflowed
);
  import rls_pkg::*;

  localparam int SW = 5*COUNT_BITS + 1;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [SW-1:0] push_data, pop_data;

  rls_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  rls_fifo #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rls_back #(.COUNT_BITS(COUNT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_run_total    (out_run_total),
    .out_longest_run  (out_longest_run),
    .out_mean_q8      (out_mean_q8),
    .out_deviation_q8 (out_deviation_q8),
    .out_overflowed   (out_overflowed)
  );
endmodule

[rtl/rls_fifo.sv]
// small request queue between the front and back parts
// depends on nothing but its parameters
module rls_fifo #(
  parameter int WIDTH = 81,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end
endmodule

[rtl/rls_front.sv]
// front part: configuration registers and per-byte run accumulation
// depends on rls_pkg; pushes one snapshot request per string end
module rls_front #(
  parameter int COUNT_BITS = rls_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rls_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rls_pkg::TEXT_W-1:0]    in_text_byte,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [5*COUNT_BITS:0]         push_data
);
  import rls_pkg::*;

  localparam int C = COUNT_BITS;

  logic [CFG_W-1:0] search_r, break_r;
  logic [C-1:0]     cur_r, cur_nxt, n_r, n_nxt, s_r, s_nxt, mx_r, mx_nxt;
  logic [2*C-1:0]   sq_r, sq_nxt, cur_sq;
  logic             sat_r, sat_nxt;
  logic [C:0]       cur_inc, n_inc, s_add;
  logic [2*C:0]     sq_add;
  logic             acc, is_end, hit, close;

  always_comb begin
    acc     = in_valid && in_ready;
    is_end  = (in_text_byte == END_BYTE);
    hit     = !is_end && (in_text_byte == search_r);
    close   = !hit && (is_end || (in_text_byte == break_r));
    cur_inc = {1'b0, cur_r} + (C+1)'(1);
    n_inc   = {1'b0, n_r} + (C+1)'(1);
    s_add   = {1'b0, s_r} + {1'b0, cur_r};
    cur_sq  = cur_r * cur_r;
    sq_add  = {1'b0, sq_r} + {1'b0, cur_sq};
    cur_nxt = cur_r;
    n_nxt   = n_r;
    s_nxt   = s_r;
    sq_nxt  = sq_r;
    mx_nxt  = mx_r;
    sat_nxt = sat_r;
    if (hit) begin
      cur_nxt = cur_inc[C] ? '1 : cur_inc[C-1:0];
      sat_nxt = sat_r | cur_inc[C];
    end else if (close) begin
      n_nxt   = n_inc[C] ? '1 : n_inc[C-1:0];
      s_nxt   = s_add[C] ? '1 : s_add[C-1:0];
      sq_nxt  = sq_add[2*C] ? '1 : sq_add[2*C-1:0];
      mx_nxt  = (cur_r > mx_r) ? cur_r : mx_r;
      sat_nxt = sat_r | n_inc[C] | s_add[C] | sq_add[2*C];
      cur_nxt = '0;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = acc && is_end;
  assign push_data  = {sat_nxt, mx_nxt, sq_nxt, s_nxt, n_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_r <= SEARCH_RST;
      break_r  <= BREAK_RST;
      cur_r    <= '0;
      n_r      <= '0;
      s_r      <= '0;
      sq_r     <= '0;
      mx_r     <= '0;
      sat_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEARCH: search_r <= cfg_wdata;
          REG_BREAK:  break_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc) begin
        if (is_end) begin
          cur_r <= '0;
          n_r   <= '0;
          s_r   <= '0;
          sq_r  <= '0;
          mx_r  <= '0;
          sat_r <= 1'b0;
        end else begin
          cur_r <= cur_nxt;
          n_r   <= n_nxt;
          s_r   <= s_nxt;
          sq_r  <= sq_nxt;
          mx_r  <= mx_nxt;
          sat_r <= sat_nxt;
        end
      end
    end
  end
endmodule

[rtl/rls_back.sv]
// back part: mean division, variance division and square root per request
// depends on rls_pkg; one shared multiplier, two bit-serial dividers and a bit-serial root
module rls_back #(
  parameter int COUNT_BITS    = rls_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = rls_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  logic [5*COUNT_BITS:0]       pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rls_pkg::TOTAL_W-1:0] out_run_total,
  output logic [rls_pkg::LONG_W-1:0]  out_longest_run,
  output logic [rls_pkg::STAT_W-1:0]  out_mean_q8,
  output logic [rls_pkg::STAT_W-1:0]  out_deviation_q8,
  output logic                        out_overflowed
);
  import rls_pkg::*;

  localparam int C  = COUNT_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int MW = C + F;
  localparam int DW = 3*C + 2*F;
  localparam int QW = ROOT_W;
  localparam int CW = $clog2(DW + 1);

  back_state_t     state_r;
  logic [CW-1:0]   cnt_r;
  logic [C-1:0]    n_r, s_r, mx_r;
  logic [2*C-1:0]  sq_r, s2_r, d_r, prod;
  logic            sat_r, dz_r;
  logic [3*C-1:0]  nsq_r;
  logic [C-1:0]    mul_a, mul_b;
  logic [MW-1:0]   md_r, mq_r, mq_fin;
  logic [C-1:0]    mrem_r;
  logic [C:0]      msh, mrem_n;
  logic            mge;
  logic [DW-1:0]   dd_r;
  logic [2*C-1:0]  drem_r;
  logic [2*C:0]    dsh, drem_n;
  logic            dge, qovf_fin;
  logic [QW-1:0]   q_r, q_fin, v_r, res_r, bit_r, sq_t, res_n;
  logic            qovf_r, sge;
  logic [STAT_W-1:0] dev_r;
  logic            load;
  logic [31:0]     n32, mx32;
  logic [63:0]     mq64;

  always_comb begin
    mul_a = (cnt_r == CW'(2)) ? s_r : n_r;
    case (cnt_r[1:0])
      2'd0:    mul_b = sq_r[C-1:0];
      2'd1:    mul_b = sq_r[2*C-1:C];
      2'd2:    mul_b = s_r;
      default: mul_b = n_r - C'(1);
    endcase
    prod = mul_a * mul_b;

    msh    = {mrem_r, md_r[MW-1]};
    mge    = (msh >= {1'b0, n_r});
    mrem_n = mge ? msh - {1'b0, n_r} : msh;
    mq_fin = {mq_r[MW-2:0], mge};

    dsh      = {drem_r, dd_r[DW-1]};
    dge      = (dsh >= {1'b0, d_r});
    drem_n   = dge ? dsh - {1'b0, d_r} : dsh;
    q_fin    = {q_r[QW-2:0], dge};
    qovf_fin = qovf_r | q_r[QW-1] | q_r[QW-2];

    sq_t  = res_r + bit_r;
    sge   = (v_r >= sq_t);
    res_n = sge ? (res_r >> 1) + bit_r : (res_r >> 1);

    load = (state_r == ST_DONE) && (!out_valid || out_ready);
    n32  = 32'(n_r);
    mx32 = 32'(mx_r);
    mq64 = 64'(mq_r);
  end

  assign pop_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            {sat_r, mx_r, sq_r, s_r, n_r} <= pop_data;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (cnt_r[1:0])
            2'd0:    nsq_r <= (3*C)'(prod);
            2'd1:    nsq_r <= nsq_r + ((3*C)'(prod) << C);
            2'd2:    s2_r  <= prod;
            default: d_r   <= prod;
          endcase
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(3)) begin
            state_r <= ST_SUB;
          end
        end
        ST_SUB: begin
          dz_r    <= (n_r < C'(2)) || (nsq_r < (3*C)'(s2_r));
          dd_r    <= DW'(nsq_r - (3*C)'(s2_r)) << (2*F);
          md_r    <= MW'(s_r) << F;
          mrem_r  <= '0;
          mq_r    <= '0;
          drem_r  <= '0;
          q_r     <= '0;
          qovf_r  <= 1'b0;
          cnt_r   <= '0;
          state_r <= ST_MDIV;
        end
        ST_MDIV: begin
          mrem_r <= mrem_n[C-1:0];
          mq_r   <= mq_fin;
          md_r   <= md_r << 1;
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == CW'(MW - 1)) begin
            cnt_r <= '0;
            if (dz_r) begin
              dev_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_DDIV;
            end
          end
        end
        ST_DDIV: begin
          drem_r <= drem_n[2*C-1:0];
          q_r    <= q_fin;
          qovf_r <= qovf_r | q_r[QW-1];
          dd_r   <= dd_r << 1;
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == CW'(DW - 1)) begin
            cnt_r <= '0;
            v_r   <= q_fin;
            res_r <= '0;
            bit_r <= QW'(1) << (QW - 1);
            if (qovf_fin) begin
              dev_r   <= '1;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (sge) begin
            v_r <= v_r - sq_t;
          end
          res_r <= res_n;
          bit_r <= bit_r >> 2;
          if (bit_r == QW'(1)) begin
            dev_r   <= (res_n[QW-1:STAT_W] != '0) ? '1 : res_n[STAT_W-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_run_total    <= (n32 > 32'hFFFF) ? '1 : n32[TOTAL_W-1:0];
      out_longest_run  <= (mx32 > 32'hFFFF) ? '1 : mx32[LONG_W-1:0];
      out_mean_q8      <= (mq64 > 64'hFF_FFFF) ? '1 : mq64[STAT_W-1:0];
      out_deviation_q8 <= dev_r;
      out_overflowed   <= sat_r;
    end
  end
endmodule

[rtl/rls_checker.sv]
// port-level checks on the run length statistics unit, bound to the top level
// depends on rls_pkg and run_length_statistics_unit_defines.svh
`include "run_length_statistics_unit_defines.svh"

module rls_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rls_pkg::TOTAL_W-1:0] out_run_total,
  input logic [rls_pkg::STAT_W-1:0]  out_deviation_q8
);
  import rls_pkg::*;

  logic single_run;

  assign single_run = out_valid && (out_run_total == TOTAL_W'(1));

  `RLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RLS_ASSERT_IMPL(a_total_nonzero, clk, rst_n, out_valid, out_run_total != '0)
  `RLS_ASSERT_IMPL(a_single_run_dev, clk, rst_n, single_run, out_deviation_q8 == '0)
  `RLS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)
endmodule

bind run_length_statistics_unit rls_checker u_rls_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_run_total    (out_run_total),
  .out_deviation_q8 (out_deviation_q8)
);

[tb/run_length_statistics_checker.sv]
// checker for the run length statistics unit: predicts each string result from the
// observed text requests and register writes, and compares the results field by field
// depends on rls_pkg
module run_length_statistics_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rls_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [rls_pkg::TEXT_W-1:0]    in_text_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [rls_pkg::TOTAL_W-1:0]   out_run_total,
  input  logic [rls_pkg::LONG_W-1:0]    out_longest_run,
  input  logic [rls_pkg::STAT_W-1:0]    out_mean_q8,
  input  logic [rls_pkg::STAT_W-1:0]    out_deviation_q8,
  input  logic                          out_overflowed,
  output int                            errors,
  output int                            pending
);
  import rls_pkg::*;

  localparam longint unsigned CNT_LIM = 64'hFFFF;
  localparam longint unsigned SQ_LIM  = 64'hFFFF_FFFF;
  localparam longint unsigned LIM24   = 64'hFF_FFFF;

  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic [LONG_W-1:0]  longest;
    logic [STAT_W-1:0]  mean;
    logic [STAT_W-1:0]  dev;
    logic               ovf;
  } string_stats_t;

  string_stats_t expected_stats[$];

  logic [CFG_W-1:0] search_reg, break_reg;
  longint unsigned cur_run, runs, sum, sq_sum, longest;
  bit sat;

  assign pending = expected_stats.size();

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned lim, ref bit flag);
    if (a > lim || b > lim - a) begin
      flag = 1;
      return lim;
    end
    return a + b;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [STAT_W-1:0] deviation(longint unsigned n, longint unsigned s,
                                                  longint unsigned sq);
    logic [127:0] nsq, s2, q, d;
    logic [63:0]  r;
    nsq = 128'(n) * 128'(sq);
    s2  = 128'(s) * 128'(s);
    if (nsq < s2) return '0;
    d = 128'(n) * 128'(n - 1);
    q = ((nsq - s2) << (2 * FRACTION_BITS_DEF)) / d;
    if (q >= (128'h1 << 56)) return STAT_W'(LIM24);
    r = int_sqrt(q[63:0]);
    return (r > LIM24) ? STAT_W'(LIM24) : STAT_W'(r);
  endfunction

  task automatic take_text(logic [TEXT_W-1:0] c);
    string_stats_t st;
    longint unsigned mq;
    if (c != END_BYTE && c == search_reg) begin
      cur_run = sat_add(cur_run, 1, CNT_LIM, sat);
      return;
    end
    if (c != END_BYTE && c != break_reg) return;
    runs = sat_add(runs, 1, CNT_LIM, sat);
    if (cur_run > longest) longest = cur_run;
    sum = sat_add(sum, cur_run, CNT_LIM, sat);
    sq_sum = sat_add(sq_sum, cur_run * cur_run, SQ_LIM, sat);
    cur_run = 0;
    if (c != END_BYTE) return;
    mq = (sum << FRACTION_BITS_DEF) / runs;
    st.total   = TOTAL_W'(runs);
    st.longest = LONG_W'(longest);
    st.mean    = (mq > LIM24) ? STAT_W'(LIM24) : STAT_W'(mq);
    st.dev     = (runs >= 2) ? deviation(runs, sum, sq_sum) : '0;
    st.ovf     = sat;
    expected_stats.push_back(st);
    runs = 0; sum = 0; sq_sum = 0; longest = 0; sat = 0;
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    string_stats_t w;
    if (!rst_n) begin
      search_reg = SEARCH_RST;
      break_reg  = BREAK_RST;
      cur_run = 0; runs = 0; sum = 0; sq_sum = 0; longest = 0; sat = 0;
      expected_stats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SEARCH) search_reg = cfg_wdata;
        else if (cfg_index == REG_BREAK) break_reg = cfg_wdata;
      end
      if (in_valid && in_ready) take_text(in_text_byte);
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          $display("result with no string end pending");
          errors++;
        end else begin
          w = expected_stats.pop_front();
          if (out_run_total !== w.total) report("run_total", out_run_total, w.total);
          if (out_longest_run !== w.longest)
            report("longest_run", out_longest_run, w.longest);
          if (out_mean_q8 !== w.mean) report("mean_q8", out_mean_q8, w.mean);
          if (out_deviation_q8 !== w.dev)
            report("deviation_q8", out_deviation_q8, w.dev);
          if (out_overflowed !== w.ovf) report("overflowed", out_overflowed, w.ovf);
        end
      end
    end
  end
endmodule

[tb/testbench.sv]
// stimulus and verdict for the run length statistics unit: directed and random strings
// under several register settings, random idling on both channels
// depends on rls_pkg, run_length_statistics_unit and run_length_statistics_checker
module testbench;
  import rls_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 150;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEARCH;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [TEXT_W-1:0]    in_text_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [TOTAL_W-1:0]   out_run_total;
  logic [LONG_W-1:0]    out_longest_run;
  logic [STAT_W-1:0]    out_mean_q8;
  logic [STAT_W-1:0]    out_deviation_q8;
  logic                 out_overflowed;
  int                   errors, pending;

  int gap_max = 10;
  int stall_max = 10;
  int stall_left = 0;
  int idle_cycles = 0;
  int sent = 0;
  logic [CFG_W-1:0] cur_search = SEARCH_RST, cur_break = BREAK_RST;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  run_length_statistics_unit dut (.*);

  run_length_statistics_checker chk (.*);

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (out_valid && out_ready) begin
      stall_left = $urandom_range(0, stall_max);
      if (stall_left > 0) out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(logic [TEXT_W-1:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_text_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] s, logic [CFG_W-1:0] b);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= REG_SEARCH;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= REG_BREAK;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 0;
    cur_search = s;
    cur_break = b;
  endtask

  task automatic send_run(int len);
    repeat (len) send(cur_search);
  endtask

  task automatic rand_string();
    int len, r;
    len = $urandom_range(0, 24);
    repeat (len) begin
      r = $urandom_range(0, 9);
      if (r < 5) send(cur_search);
      else if (r < 8) send(cur_break);
      else send(TEXT_W'($urandom_range(0, 255)));
    end
    send(END_BYTE);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed strings at reset settings
    send(END_BYTE);
    send_run(3); send(END_BYTE);
    send_run(2); send(cur_break); send_run(5); send(cur_break); send(cur_break);
    send(8'hFF); send(END_BYTE);
    send(8'h55); send(8'hAA); send(END_BYTE);

    set_regs(8'hFF, 8'h01);
    send_run(4); send(8'h01); send_run(1); send(END_BYTE);

    // search equals break
    set_regs(8'h41, 8'h41);
    send_run(6); send(END_BYTE);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(SEARCH_RST, BREAK_RST);
        1: set_regs(8'hFF, 8'h01);
        2: set_regs(8'h01, 8'hFF);
        3: set_regs(8'h7E, 8'h7E);
        default: set_regs(CFG_W'($urandom_range(1, 255)), CFG_W'($urandom_range(1, 255)));
      endcase
      gap_max = (ph % 3 == 1) ? 0 : 10;
      stall_max = (ph % 3 == 2) ? 0 : 10;
      while (sent < 330 * (ph + 1)) rand_string();
    end
    in_valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
